[rtl/core/deque_with_match_remove_top_assert.svh]
// ----------------------------------------------------------------------------
// deque_with_match_remove_top_assert.svh
// Assertion macros shared by the deque checker
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_MATCH_REMOVE_TOP_ASSERT_SVH
`define DEQUE_WITH_MATCH_REMOVE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define DQM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define DQM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/dqm_pkg.sv]
// ----------------------------------------------------------------------------
// dqm_pkg
// Command, status and cell control types for the match-remove deque
// ----------------------------------------------------------------------------
package dqm_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;
  localparam logic [2:0] CMD_FIND       = 3'd6;
  localparam logic [2:0] CMD_REMOVE     = 3'd7;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_NOMATCH = 2'd3;

  // register map
  localparam int unsigned APB_ADDR_W     = 3;
  localparam logic        REG_MATCH_MASK = 1'b0;
  localparam int unsigned MASK_W         = 32;

  // what a cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,   // take the entry behind (toward the back)
    CELL_SHR,   // take the entry ahead (toward the front)
    CELL_LOAD   // take the incoming item
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

[rtl/core/dqm_if.sv]
// ----------------------------------------------------------------------------
// dqm_if
// Valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface dqm_in_if #(
  parameter int ITEM_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            cmd;
  logic [ITEM_WIDTH-1:0] item;

  modport source (output valid, output cmd, output item, input ready);
  modport sink   (input valid, input cmd, input item, output ready);
endinterface

interface dqm_out_if #(
  parameter int ITEM_WIDTH = 32,
  parameter int CNT_WIDTH  = 5
);
  logic                  valid;
  logic                  ready;
  logic [ITEM_WIDTH-1:0] value;
  logic [1:0]            status;
  logic [CNT_WIDTH-1:0]  occupancy;

  modport source (output valid, output value, output status, output occupancy, input ready);
  modport sink   (input valid, input value, input status, input occupancy, output ready);
endinterface

[rtl/core/dqm_cell.sv]
// ----------------------------------------------------------------------------
// dqm_cell
// One storage cell of the deque chain: holds, shifts either way or loads
// ----------------------------------------------------------------------------
module dqm_cell #(
  parameter int ITEM_WIDTH = 32
) (
  input  logic                   clk_i,
  input  dqm_pkg::cell_ctrl_t    ctrl_i,
  input  logic [ITEM_WIDTH-1:0]  prev_i,
  input  logic [ITEM_WIDTH-1:0]  next_i,
  input  logic [ITEM_WIDTH-1:0]  load_i,
  output logic [ITEM_WIDTH-1:0]  data_o
);
  import dqm_pkg::*;

  logic [ITEM_WIDTH-1:0] data_q;
  logic [ITEM_WIDTH-1:0] data_d;

  // next entry select
  always_comb begin
    case (ctrl_i.op)
      CELL_SHL:  data_d = next_i;
      CELL_SHR:  data_d = prev_i;
      CELL_LOAD: data_d = load_i;
      default:   data_d = data_q;
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/core/deque_with_match_remove_top.sv]
// Bounded deque of DEPTH items held in a chain of cells, cell 0 always the
// front. Push front, push back, pop front and peek front finish in the cycle
// the item is accepted. Pop back, peek back, find and remove rotate the whole
// chain once, one place per cycle, and the block takes no new item meanwhile;
// the front entry is compared against the masked key as it passes
// cell 0, and remove closes the gap by feeding the tail from cell 1 from the
// matched step on. The result enters an output register, which frees the
// input side for the next item while the result waits. No clearing pass.
// ----------------------------------------------------------------------------
// deque_with_match_remove_top
// Double-ended queue with masked find and ordered remove, APB mask register
// ----------------------------------------------------------------------------
module deque_with_match_remove_top #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dqm_in_if.sink                           in_if,
  dqm_out_if.source                        out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dqm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dqm_pkg::MASK_W-1:0]       pwdata,
  output logic [dqm_pkg::MASK_W-1:0]       prdata,
  output logic                             pready
);
  import dqm_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);
  localparam int CmpW = (ITEM_WIDTH < 32) ? ITEM_WIDTH : 32;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [IdxW-1:0]       step_q, step_d;
  logic [2:0]            cmd_q, cmd_d;
  logic [ITEM_WIDTH-1:0] key_q, key_d;
  logic                  found_q, found_d;
  logic [ITEM_WIDTH-1:0] hit_val_q, hit_val_d;
  logic [MASK_W-1:0]     mask_q;

  logic                  out_valid_q, out_valid_d;
  logic [ITEM_WIDTH-1:0] out_value_q, out_value_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [CntW-1:0]       out_occ_q, out_occ_d;
  logic [ITEM_WIDTH-1:0] res_value_q, res_value_d;
  logic [1:0]            res_status_q, res_status_d;

  logic                  done;
  logic [ITEM_WIDTH-1:0] done_value;
  logic [1:0]            done_status;
  logic                  out_free;
  logic                  is_empty, is_full;
  logic                  is_back_cmd;
  logic                  match_now, hit;
  logic                  tail_from_second;
  cell_op_e              glob_op;

  logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
  cell_ctrl_t            cell_ctrl [DEPTH];
  logic [ITEM_WIDTH-1:0] tail_feed;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MATCH_MASK) ? mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MATCH_MASK)) begin
      mask_q <= pwdata;
    end
  end

  // status flags and compare at the head cell
  assign out_free    = !out_valid_q || out_if.ready;
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CntW'(DEPTH));
  assign is_back_cmd = (cmd_q == CMD_POP_BACK) || (cmd_q == CMD_PEEK_BACK);
  assign match_now   = (((cell_data[0][CmpW-1:0] ^ key_q[CmpW-1:0])
                        & mask_q[CmpW-1:0]) == '0);

  assign in_if.ready = (state_q == S_IDLE);

  // command sequencer
  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    step_d           = step_q;
    cmd_d            = cmd_q;
    key_d            = key_q;
    found_d          = found_q;
    hit_val_d        = hit_val_q;
    glob_op          = CELL_HOLD;
    tail_from_second = 1'b0;
    hit              = 1'b0;
    done             = 1'b0;
    done_value       = '0;
    done_status      = STAT_OK;

    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_d   = in_if.cmd;
          key_d   = in_if.item;
          step_d  = '0;
          found_d = 1'b0;
          unique case (in_if.cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              done = 1'b1;
              if (is_full) begin
                done_status = STAT_FULL;
              end else begin
                glob_op = (in_if.cmd == CMD_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
                count_d = count_q + 1'b1;
              end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
              done = 1'b1;
              if (is_empty) begin
                done_status = STAT_EMPTY;
              end else begin
                done_value = cell_data[0];
                if (in_if.cmd == CMD_POP_FRONT) begin
                  glob_op = CELL_SHL;
                  count_d = count_q - 1'b1;
                end
              end
            end
            CMD_POP_BACK, CMD_PEEK_BACK: begin
              if (is_empty) begin
                done        = 1'b1;
                done_status = STAT_EMPTY;
              end else begin
                state_d = S_SWEEP;
              end
            end
            default: begin
              if (is_empty) begin
                done        = 1'b1;
                done_status = STAT_NOMATCH;
              end else begin
                state_d = S_SWEEP;
              end
            end
          endcase
        end
      end

      S_SWEEP: begin
        // rotate the chain; cell 0 holds position step_q
        glob_op = CELL_SHL;
        step_d  = step_q + 1'b1;
        if (is_back_cmd) begin
          hit = (CntW'(step_q) == (count_q - 1'b1));
        end else begin
          hit = !found_q && (CntW'(step_q) < count_q) && match_now;
        end
        if (hit) begin
          found_d   = 1'b1;
          hit_val_d = cell_data[0];
        end
        // remove: skip the matched entry by feeding the tail from cell 1
        tail_from_second = (cmd_q == CMD_REMOVE) && (found_q || hit);
        if (step_q == IdxW'(DEPTH - 1)) begin
          done    = 1'b1;
          state_d = S_IDLE;
          if (found_d) begin
            done_value = hit_val_d;
            if ((cmd_q == CMD_POP_BACK) || (cmd_q == CMD_REMOVE)) begin
              count_d = count_q - 1'b1;
            end
          end else begin
            done_status = STAT_NOMATCH;
          end
        end
      end

      S_WAIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // park the result when the output register is still occupied
    if (done && !out_free) begin
      state_d = S_WAIT;
    end
  end

  // output register and parked result
  always_comb begin
    out_valid_d  = out_valid_q && !out_if.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    if (done && out_free) begin
      out_valid_d  = 1'b1;
      out_value_d  = done_value;
      out_status_d = done_status;
      out_occ_d    = count_d;
    end else if (done) begin
      res_value_d  = done_value;
      res_status_d = done_status;
    end else if ((state_q == S_WAIT) && out_free) begin
      out_valid_d  = 1'b1;
      out_value_d  = res_value_q;
      out_status_d = res_status_q;
      out_occ_d    = count_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    hit_val_q    <= hit_val_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.value     = out_value_q;
  assign out_if.status    = out_status_q;
  assign out_if.occupancy = out_occ_q;

  // cell chain
  assign tail_feed = tail_from_second ? cell_data[1] : cell_data[0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ITEM_WIDTH-1:0] prev_data;
    logic [ITEM_WIDTH-1:0] next_data;

    // push front enters the head cell
    if (k == 0) begin : g_head
      assign prev_data = in_if.item;
    end else begin : g_body
      assign prev_data = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign next_data = tail_feed;
    end else begin : g_link
      assign next_data = cell_data[k+1];
    end

    // push back loads only the first free cell
    assign cell_ctrl[k].op = (glob_op == CELL_LOAD)
                           ? ((count_q == CntW'(k)) ? CELL_LOAD : CELL_HOLD)
                           : glob_op;

    dqm_cell #(
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[k]),
      .prev_i (prev_data),
      .next_i (next_data),
      .load_i (in_if.item),
      .data_o (cell_data[k])
    );
  end

endmodule

[rtl/core/dqm_checker.sv]
// ----------------------------------------------------------------------------
// dqm_checker
// Port-level checks on the result channel of the deque
// ----------------------------------------------------------------------------
`include "deque_with_match_remove_top_assert.svh"

module dqm_checker #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [ITEM_WIDTH-1:0]          out_value_i,
  input logic [1:0]                     out_status_i,
  input logic [$clog2(DEPTH + 1)-1:0]   out_occupancy_i
);
  import dqm_pkg::*;

  localparam int              CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Cap  = CntW'(DEPTH);

  logic                         res_full;
  logic                         res_empty;
  logic                         res_fail;
  logic                         res_stall;
  logic [ITEM_WIDTH+CntW+1:0]   res_word;

  // result qualifiers
  assign res_full  = out_valid_i && (out_status_i == STAT_FULL);
  assign res_empty = out_valid_i && (out_status_i == STAT_EMPTY);
  assign res_fail  = out_valid_i && (out_status_i != STAT_OK);
  assign res_stall = out_valid_i && !out_ready_i;
  assign res_word  = {out_value_i, out_status_i, out_occupancy_i};

  // count never passes the capacity
  `DQM_ASSERT_IMP(a_occ_bound, out_valid_i, out_occupancy_i <= Cap, "occupancy above depth")

  // a dropped push only happens on a full queue
  `DQM_ASSERT_IMP(a_full_occ, res_full, out_occupancy_i == Cap, "full status below depth")

  // an empty status leaves nothing behind
  `DQM_ASSERT_IMP(a_empty_occ, res_empty, out_occupancy_i == '0, "empty status with entries")

  // failed commands return a zero value
  `DQM_ASSERT_IMP(a_fail_zero, res_fail, out_value_i == '0, "nonzero value on failure")

  // a stalled result holds
  `DQM_ASSERT_NXT(a_out_hold, res_stall, out_valid_i && $stable(res_word), "stalled result changed")

endmodule

bind deque_with_match_remove_top dqm_checker #(
  .DEPTH      (DEPTH),
  .ITEM_WIDTH (ITEM_WIDTH)
) u_dqm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_value_i     (out_if.value),
  .out_status_i    (out_if.status),
  .out_occupancy_i (out_if.occupancy)
);
